FILE: hdl/magnetometer_calibrate_heading_core_macros.svh
// Assertion macros shared by the magnetometer calibration and heading core.
`ifndef MAGNETOMETER_CALIBRATE_HEADING_CORE_MACROS_SVH
`define MAGNETOMETER_CALIBRATE_HEADING_CORE_MACROS_SVH

// Check cons in the same cycle whenever ante holds
`define MCH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante holds
`define MCH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/mch_pkg.sv
// Shared types, constants and the arctangent table of the magnetometer heading core.
`default_nettype none

package mch_pkg;

  // Algorithm constants
  localparam int CORDIC_STEPS   = 16;
  localparam int COEF_FRAC_BITS = 12;
  localparam int PRE_SCALE_BITS = 14;
  localparam int HEAD_TURN      = 23040;

  // Field and datapath widths
  localparam int AXIS_W     = 16;
  localparam int DIFF_W     = AXIS_W + 1;
  localparam int PROD_W     = AXIS_W + DIFF_W;
  localparam int ACC_W      = PROD_W + 3;
  localparam int VEC_W      = 34;
  localparam int ANG_W      = 32;
  localparam int HEAD_W     = 15;
  localparam int HPROD_W    = ANG_W + HEAD_W;
  localparam int ATAN_IDX_W = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_Z = 3'd5;

  // Identity soft-iron matrix at reset
  localparam logic [AXIS_W-1:0] COEF_ONE = AXIS_W'(2 ** COEF_FRAC_BITS);
  localparam logic [AXIS_W-1:0] COEF_ZERO = '0;
  localparam logic [CFG_DATA_W-1:0] MATRIX_X_RST = {COEF_ZERO, COEF_ZERO, COEF_ONE};
  localparam logic [CFG_DATA_W-1:0] MATRIX_Y_RST = {COEF_ZERO, COEF_ONE, COEF_ZERO};
  localparam logic [CFG_DATA_W-1:0] MATRIX_Z_RST = {COEF_ONE, COEF_ZERO, COEF_ZERO};

  // Rounding and clipping constants of the matrix step
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(2 ** (COEF_FRAC_BITS - 1));
  localparam logic signed [ACC_W-1:0] ACC_AXIS_MAX = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] ACC_AXIS_MIN = ACC_W'(-32768);

  // Heading constants
  localparam logic [ANG_W-1:0]   HALF_TURN_ANG = 32'h8000_0000;
  localparam logic [HPROD_W-1:0] HEAD_ROUND    = HPROD_W'(64'h8000_0000);
  localparam logic [HEAD_W-1:0]  HEAD_TURN_V   = HEAD_W'(HEAD_TURN);

  typedef logic signed [AXIS_W-1:0] axis_t;

  // Calibrated sample travelling alongside the heading pipeline
  typedef struct packed {
    axis_t cal_x;
    axis_t cal_y;
    axis_t cal_z;
    logic  sat;
  } cal_res_t;

  // atan(2^-i) as a fraction of a turn, 2^-32 units
  function automatic logic [ANG_W-1:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
    logic [ANG_W-1:0] r;
    case (idx)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/mch_cal.sv
// Hard-iron offset, soft-iron matrix and saturation pipeline, four stages.
`default_nettype none

module mch_cal (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire mch_pkg::axis_t                 raw_x,
  input  wire mch_pkg::axis_t                 raw_y,
  input  wire mch_pkg::axis_t                 raw_z,
  input  wire mch_pkg::axis_t                 offset_x,
  input  wire mch_pkg::axis_t                 offset_y,
  input  wire mch_pkg::axis_t                 offset_z,
  input  wire logic [mch_pkg::CFG_DATA_W-1:0] row_x,
  input  wire logic [mch_pkg::CFG_DATA_W-1:0] row_y,
  input  wire logic [mch_pkg::CFG_DATA_W-1:0] row_z,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output mch_pkg::cal_res_t                   out_res
);
  import mch_pkg::*;

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  logic signed [DIFF_W-1:0] d_nxt [3];
  logic signed [DIFF_W-1:0] d_r   [3];
  logic signed [PROD_W-1:0] p_nxt [3][3];
  logic signed [PROD_W-1:0] p_r   [3][3];
  logic signed [ACC_W-1:0]  acc_nxt [3];
  logic signed [ACC_W-1:0]  acc_r   [3];
  logic signed [ACC_W-1:0]  sh      [3];
  logic [CFG_DATA_W-1:0]    row_w   [3];
  axis_t                    clip    [3];
  logic                     clip_any;
  cal_res_t                 res_nxt, res_r;

  // Each stage advances when empty or when the next one moves
  assign rdy4     = !v4_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  assign row_w[0] = row_x;
  assign row_w[1] = row_y;
  assign row_w[2] = row_z;

  // Subtract the hard-iron offsets
  always_comb begin
    d_nxt[0] = DIFF_W'(raw_x) - DIFF_W'(offset_x);
    d_nxt[1] = DIFF_W'(raw_y) - DIFF_W'(offset_y);
    d_nxt[2] = DIFF_W'(raw_z) - DIFF_W'(offset_z);
  end

  // Form all nine coefficient products
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        p_nxt[r][c] = PROD_W'(signed'(row_w[r][AXIS_W*c +: AXIS_W])) * PROD_W'(d_r[c]);
      end
    end
  end

  // Sum each row and add half an LSB for rounding
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc_nxt[r] = ACC_W'(p_r[r][0]) + ACC_W'(p_r[r][1]) + ACC_W'(p_r[r][2]) + ROUND_HALF;
    end
  end

  // Drop the fraction bits and clip to 16 bits
  always_comb begin
    clip_any = 1'b0;
    for (int a = 0; a < 3; a++) begin
      sh[a] = acc_r[a] >>> COEF_FRAC_BITS;
      if (sh[a] > ACC_AXIS_MAX) begin
        clip[a]  = AXIS_W'(ACC_AXIS_MAX);
        clip_any = 1'b1;
      end else if (sh[a] < ACC_AXIS_MIN) begin
        clip[a]  = AXIS_W'(ACC_AXIS_MIN);
        clip_any = 1'b1;
      end else begin
        clip[a] = AXIS_W'(sh[a]);
      end
    end
    res_nxt.cal_x = clip[0];
    res_nxt.cal_y = clip[1];
    res_nxt.cal_z = clip[2];
    res_nxt.sat   = clip_any;
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // Payload registers, held while a stage is stalled
  always_ff @(posedge clk) begin
    if (rdy1) d_r   <= d_nxt;
    if (rdy2) p_r   <= p_nxt;
    if (rdy3) acc_r <= acc_nxt;
    if (rdy4) res_r <= res_nxt;
  end

  assign out_valid = v4_r;
  assign out_res   = res_r;

endmodule

`default_nettype wire

FILE: hdl/mch_cordic.sv
// Heading pipeline: half-turn fold, one CORDIC vectoring step per stage, scale and wrap.
`default_nettype none

module mch_cordic (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire mch_pkg::cal_res_t          in_res,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output mch_pkg::cal_res_t               out_res,
  output logic [mch_pkg::HEAD_W-1:0]      out_heading
);
  import mch_pkg::*;

  localparam int NST = CORDIC_STEPS + 3;
  localparam int MUL = CORDIC_STEPS + 1;
  localparam int FIN = CORDIC_STEPS + 2;

  logic                    v_r   [NST];
  logic                    rdy   [NST+1];
  cal_res_t                res_r [NST];
  logic                    zero_r [FIN];
  logic signed [VEC_W-1:0] vx_r  [MUL];
  logic signed [VEC_W-1:0] vy_r  [MUL];
  logic [ANG_W-1:0]        ang_r [MUL];
  logic [HPROD_W-1:0]      prod_r;
  logic [HPROD_W-1:0]      prod_rnd;
  logic [HEAD_W-1:0]       head_raw;
  logic [HEAD_W-1:0]       head_nxt, head_r;

  logic signed [VEC_W-1:0] vx0_pre, vy0_pre, vx0_nxt, vy0_nxt;
  logic [ANG_W-1:0]        ang0_nxt;

  // Ready chain from the output back to the input
  assign rdy[NST] = out_ready;
  for (genvar k = 0; k < NST; k++) begin : g_rdy
    assign rdy[k] = !v_r[k] || rdy[k+1];
  end
  assign in_ready = rdy[0];

  // Valid bits and passenger data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NST; k++) v_r[k] <= 1'b0;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) res_r[0] <= in_res;
    for (int k = 1; k < NST; k++) begin
      if (rdy[k]) res_r[k] <= res_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) zero_r[0] <= (in_res.cal_x == '0) && (in_res.cal_y == '0);
    for (int k = 1; k < FIN; k++) begin
      if (rdy[k]) zero_r[k] <= zero_r[k-1];
    end
  end

  // Scale the vector and fold the left half-plane by half a turn
  always_comb begin
    vx0_pre = VEC_W'(in_res.cal_y) <<< PRE_SCALE_BITS;
    vy0_pre = VEC_W'(in_res.cal_x) <<< PRE_SCALE_BITS;
    if (vx0_pre < 0) begin
      vx0_nxt  = -vx0_pre;
      vy0_nxt  = -vy0_pre;
      ang0_nxt = HALF_TURN_ANG;
    end else begin
      vx0_nxt  = vx0_pre;
      vy0_nxt  = vy0_pre;
      ang0_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      vx_r[0]  <= vx0_nxt;
      vy_r[0]  <= vy0_nxt;
      ang_r[0] <= ang0_nxt;
    end
  end

  // One vectoring step per stage: rotate y toward zero
  for (genvar gi = 0; gi < CORDIC_STEPS; gi++) begin : g_step
    logic signed [VEC_W-1:0] dx, dy;
    logic [ANG_W-1:0]        da;

    assign dx = vy_r[gi] >>> gi;
    assign dy = vx_r[gi] >>> gi;
    assign da = atan_turn(ATAN_IDX_W'(gi));

    always_ff @(posedge clk) begin
      if (rdy[gi+1]) begin
        if (!vy_r[gi][VEC_W-1]) begin
          vx_r[gi+1]  <= vx_r[gi] + dx;
          vy_r[gi+1]  <= vy_r[gi] - dy;
          ang_r[gi+1] <= ang_r[gi] + da;
        end else begin
          vx_r[gi+1]  <= vx_r[gi] - dx;
          vy_r[gi+1]  <= vy_r[gi] + dy;
          ang_r[gi+1] <= ang_r[gi] - da;
        end
      end
    end
  end

  // Scale the turn fraction to 1/64 degree
  always_ff @(posedge clk) begin
    if (rdy[MUL]) prod_r <= HPROD_W'(ang_r[CORDIC_STEPS]) * HPROD_W'(HEAD_TURN_V);
  end

  // Round, wrap a full turn to zero and force zero for a null vector
  always_comb begin
    prod_rnd = prod_r + HEAD_ROUND;
    head_raw = prod_rnd[HPROD_W-1:ANG_W];
    if (zero_r[MUL] || (head_raw >= HEAD_TURN_V)) begin
      head_nxt = '0;
    end else begin
      head_nxt = head_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[FIN]) head_r <= head_nxt;
  end

  assign out_valid   = v_r[FIN];
  assign out_res     = res_r[FIN];
  assign out_heading = head_r;

endmodule

`default_nettype wire

FILE: hdl/magnetometer_calibrate_heading_core.sv
// Top level of the magnetometer calibration and compass heading core.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------------------
//   cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//   in      | in        | in_valid / in_ready   | in_raw_x, in_raw_y, in_raw_z
//   out     | out       | out_valid / out_ready | out_cal_x/y/z, out_heading, out_saturated
//
// One transaction is accepted per cycle whenever in_ready is high; each result passes
// through four calibration stages, then a fold stage, one stage per CORDIC step, a
// scaling multiply and a rounding stage.
// Every stage holds its own valid bit; a stalled output freezes only the full stages
// behind it, and empty stages keep filling. Reset is synchronous and active low; it
// empties the pipeline and loads zero offsets and an identity matrix.
`default_nettype none
`include "magnetometer_calibrate_heading_core_macros.svh"

module magnetometer_calibrate_heading_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [mch_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mch_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire mch_pkg::axis_t                 in_raw_x,
  input  wire mch_pkg::axis_t                 in_raw_y,
  input  wire mch_pkg::axis_t                 in_raw_z,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output mch_pkg::axis_t                      out_cal_x,
  output mch_pkg::axis_t                      out_cal_y,
  output mch_pkg::axis_t                      out_cal_z,
  output logic [mch_pkg::HEAD_W-1:0]          out_heading,
  output logic                                out_saturated
);
  import mch_pkg::*;

  axis_t                 offset_x_r, offset_y_r, offset_z_r;
  logic [CFG_DATA_W-1:0] row_x_r, row_y_r, row_z_r;

  logic     cal_valid, cal_ready;
  cal_res_t cal_res;
  cal_res_t fin_res;

  // Configuration registers; writes to unused indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_x_r <= '0;
      offset_y_r <= '0;
      offset_z_r <= '0;
      row_x_r    <= MATRIX_X_RST;
      row_y_r    <= MATRIX_Y_RST;
      row_z_r    <= MATRIX_Z_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_OFFSET_X: offset_x_r <= cfg_data[AXIS_W-1:0];
        REG_OFFSET_Y: offset_y_r <= cfg_data[AXIS_W-1:0];
        REG_OFFSET_Z: offset_z_r <= cfg_data[AXIS_W-1:0];
        REG_MATRIX_X: row_x_r    <= cfg_data;
        REG_MATRIX_Y: row_y_r    <= cfg_data;
        REG_MATRIX_Z: row_z_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Calibration stages
  mch_cal u_cal (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .raw_x     (in_raw_x),
    .raw_y     (in_raw_y),
    .raw_z     (in_raw_z),
    .offset_x  (offset_x_r),
    .offset_y  (offset_y_r),
    .offset_z  (offset_z_r),
    .row_x     (row_x_r),
    .row_y     (row_y_r),
    .row_z     (row_z_r),
    .out_valid (cal_valid),
    .out_ready (cal_ready),
    .out_res   (cal_res)
  );

  // Heading stages
  mch_cordic u_cordic (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (cal_valid),
    .in_ready    (cal_ready),
    .in_res      (cal_res),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_res     (fin_res),
    .out_heading (out_heading)
  );

  assign out_cal_x     = fin_res.cal_x;
  assign out_cal_y     = fin_res.cal_y;
  assign out_cal_z     = fin_res.cal_z;
  assign out_saturated = fin_res.sat;

  // Heading always lies below a full turn
  `MCH_ASSERT_NOW(a_heading_range, out_valid, out_heading < HEAD_TURN_V, "heading beyond a full turn")

  // A null horizontal vector reports a heading of zero
  `MCH_ASSERT_NOW(a_null_heading, out_valid && (out_cal_x == '0) && (out_cal_y == '0), out_heading == '0, "null vector with nonzero heading")

  // An offset write lands in its register on the next cycle
  `MCH_ASSERT_NEXT(a_cfg_offset_x, cfg_valid && cfg_ready && (cfg_index == REG_OFFSET_X), offset_x_r == $past(cfg_data[AXIS_W-1:0]), "offset x write lost")

endmodule

`default_nettype wire
